// File: hw/rtl/tsbs_pkg.sv
// Shared opcodes and result type for the table search block.
`default_nettype none

package tsbs_pkg;

  localparam int unsigned IDX_W = 10;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic             bisect_found;
    logic [IDX_W-1:0] bisect_index;
    logic             linear_found;
    logic [IDX_W-1:0] linear_index;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsbs_core.sv
// Table memory, entry count and the linear-scan / binary-search sequencer.
`default_nettype none

module tsbs_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [31:0]         value_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output tsbs_pkg::res_t           res_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIN   = 3'd1;
  localparam logic [2:0] S_BINIT = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_BCMP  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [31:0] mem_q [TABLE_DEPTH];
  logic [31:0] rdata_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [31:0]         key_q, key_d;
  logic [CW-1:0]       issue_q, issue_d;
  logic                cmp_v_q, cmp_v_d;
  logic [AW-1:0]       cmp_a_q, cmp_a_d;
  logic signed [CW:0]  lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]       mid_q, mid_d;
  logic                lin_f_q, lin_f_d, bis_f_q, bis_f_d;
  logic [AW-1:0]       lin_i_q, lin_i_d, bis_i_q, bis_i_d;

  logic [CW+1:0]       sum;
  logic [AW-1:0]       mid_c;
  logic signed [CW:0]  mid_ext;
  logic [31:0]         lin_wide, bis_wide;

  assign wr_en   = start_i && (opcode_i == tsbs_pkg::OP_LOAD) && (count_q < CW'(TABLE_DEPTH));
  assign sum     = (CW+2)'(lo_q) + (CW+2)'(hi_q);
  assign mid_c   = sum[AW:1];
  assign mid_ext = $signed({{(CW+1-AW){1'b0}}, mid_q});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    key_d   = key_q;
    issue_d = issue_q;
    cmp_v_d = 1'b0;
    cmp_a_d = cmp_a_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    lin_f_d = lin_f_q;
    lin_i_d = lin_i_q;
    bis_f_d = bis_f_q;
    bis_i_d = bis_i_q;
    rd_en   = 1'b0;
    rd_addr = issue_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          priority if (opcode_i == tsbs_pkg::OP_LOAD) begin
            if (wr_en) begin
              count_d = count_q + CW'(1);
            end
          end else if (opcode_i == tsbs_pkg::OP_CLEAR) begin
            count_d = '0;
          end else if (opcode_i == tsbs_pkg::OP_SEARCH) begin
            key_d   = value_i;
            issue_d = '0;
            lin_f_d = 1'b0;
            lin_i_d = '0;
            bis_f_d = 1'b0;
            bis_i_d = '0;
            state_d = S_LIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LIN: begin
        if (cmp_v_q && (rdata_q == key_q)) begin
          lin_f_d = 1'b1;
          lin_i_d = cmp_a_q;
          state_d = S_BINIT;
        end else if (issue_q < count_q) begin
          rd_en   = 1'b1;
          cmp_v_d = 1'b1;
          cmp_a_d = issue_q[AW-1:0];
          issue_d = issue_q + CW'(1);
        end else begin
          state_d = S_BINIT;
        end
      end
      S_BINIT: begin
        lo_d    = '0;
        hi_d    = $signed({1'b0, count_q}) - (CW+1)'(1);
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (lo_q > hi_q) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mid_c;
          mid_d   = mid_c;
          state_d = S_BCMP;
        end
      end
      S_BCMP: begin
        if (rdata_q == key_q) begin
          bis_f_d = 1'b1;
          bis_i_d = mid_q;
          state_d = S_DONE;
        end else begin
          if ($signed(rdata_q) > $signed(key_q)) begin
            hi_d = mid_ext - (CW+1)'(1);
          end else begin
            lo_d = mid_ext + (CW+1)'(1);
          end
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    issue_q <= issue_d;
    cmp_a_q <= cmp_a_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    lin_f_q <= lin_f_d;
    lin_i_q <= lin_i_d;
    bis_f_q <= bis_f_d;
    bis_i_q <= bis_i_d;
  end

  assign lin_wide = 32'(lin_i_q);
  assign bis_wide = 32'(bis_i_q);

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.linear_found = lin_f_q;
    res_o.linear_index = lin_wide[tsbs_pkg::IDX_W-1:0];
    res_o.bisect_found = bis_f_q;
    res_o.bisect_index = bis_wide[tsbs_pkg::IDX_W-1:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/table_sequential_and_binary_search_core.sv
// Top level of the table search block: stream ports and result register.
`default_nettype none

// Keeps up to TABLE_DEPTH signed words in one single-port-read memory. Load
// and clear complete in the idle state. A search runs a linear scan (one
// memory read per entry, stopping at the first match) and then a binary
// search (each probe a read, then a compare), and then hands over the result.
// All timing is set by the single memory read port. A result waits in an
// output register while loads and clears continue to be taken.
module table_sequential_and_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [0] linear_found, [10:1] linear_index,
                                          // [11] bisect_found, [21:12] bisect_index
);

  logic           idle;
  logic           res_valid;
  logic           res_ready;
  tsbs_pkg::res_t res;
  tsbs_pkg::res_t out_q;
  logic           out_valid_q, out_valid_d;

  tsbs_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .value_i    (s_axis_tdata),
    .idle_o     (idle),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign s_axis_tready = idle;
  assign res_ready     = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.bisect_index, out_q.bisect_found,
                          out_q.linear_index, out_q.linear_found};

endmodule

`default_nettype wire
